// ----- rtl/core/tffa_pkg.sv -----
// ----------------------------------------------------------------------------
// tffa_pkg
// Shared types and constants of the tagged first-fit heap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package tffa_pkg;

    // fixed field widths
    localparam int SIZE_W  = 13;
    localparam int ADDR_W  = 32;
    localparam int STAT_W  = 2;

    // block starts are aligned to 4 units
    localparam int ALIGN_BITS = 2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STAT_W-1:0] ST_IGNORED  = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_SPACE = 2'd2;
    localparam logic [STAT_W-1:0] ST_BAD_FREE = 2'd3;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_ALLOC,
        S_SCAN,
        S_FILL,
        S_FREE_CHK,
        S_FREE_TAG,
        S_CLR
    } state_t;

    // sequencer -> run unit
    typedef struct packed {
        logic restart;
        logic step;
    } run_ctrl_t;

    // run unit -> sequencer
    typedef struct packed {
        logic unit_free;
        logic tag_match;
        logic fit;
    } run_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/tffa_tag_ram.sv -----
// ----------------------------------------------------------------------------
// tffa_tag_ram
// Tag store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tffa_tag_ram #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12,
    parameter int DATA_W = 16
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/core/tffa_run_unit.sv -----
// ----------------------------------------------------------------------------
// tffa_run_unit
// Shared compare unit: free-run counter, fit and alignment test, tag match.
// ----------------------------------------------------------------------------
`default_nettype none

module tffa_run_unit #(
    parameter int OFF_W  = 12,
    parameter int TAG_W  = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire tffa_pkg::run_ctrl_t         ctrl,
    input  wire logic [TAG_W-1:0]            rdata,
    input  wire logic [TAG_W-1:0]            ref_tag,
    input  wire logic [OFF_W-1:0]            chk_idx,
    input  wire logic [tffa_pkg::SIZE_W-1:0] size,
    input  wire logic [tffa_pkg::ALIGN_BITS-1:0] heap_lo,
    output tffa_pkg::run_stat_t              stat,
    output logic      [OFF_W-1:0]            start_off
);

    localparam int CNT_W = OFF_W + 1;
    localparam int CMP_W = ((OFF_W > tffa_pkg::SIZE_W) ? OFF_W : tffa_pkg::SIZE_W) + 1;

    logic [CNT_W-1:0] run_reg;
    logic [CNT_W-1:0] run_next;
    logic [CNT_W-1:0] run_cur;
    logic [CMP_W-1:0] start_full;
    logic [tffa_pkg::ALIGN_BITS-1:0] abs_lo;
    logic             enough;

    always_comb
    begin
        stat.unit_free = (rdata == '0);
        stat.tag_match = (rdata == ref_tag);
        run_cur        = stat.unit_free ? (run_reg + CNT_W'(1)) : '0;
        enough         = (CMP_W'(run_cur) >= CMP_W'(size));
        // start of the run that ends at chk_idx
        start_full     = CMP_W'(chk_idx) + CMP_W'(1) - CMP_W'(size);
        start_off      = start_full[OFF_W-1:0];
        abs_lo         = heap_lo + start_off[tffa_pkg::ALIGN_BITS-1:0];
        stat.fit       = enough && (abs_lo == '0);

        run_next = run_reg;
        if (ctrl.restart)
        begin
            run_next = '0;
        end
        else if (ctrl.step)
        begin
            run_next = run_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/tagged_first_fit_heap_allocator.sv -----
// ----------------------------------------------------------------------------
// tagged_first_fit_heap_allocator
// First-fit heap allocator over a tag-per-unit store, walked one unit a cycle.
// ----------------------------------------------------------------------------
//  channel   ports                                 handshake
//  -------   ------------------------------------  ---------------------------
//  request   op, alloc_size, free_addr             start & !busy
//  result    block_addr, status                    done, one cycle, no stall
//  config    cfg_wdata (heap_start)                cfg_we
//
//  After reset a clearing pass zeroes the tag store while busy is high.
//  Allocate: a setup state (S_ALLOC), then the scan reads one unit a cycle
//  over units 0 to high-water + size (clipped to the store), then S_FILL
//  writes the block tag into every unit of the block.
//  Free: range and tag checks, then S_CLR clears units onward while the tag holds, up to high water.
//  Zero size or null address answers in the cycle after the beat.
//  Results cannot be stalled; busy stays high until the result cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tagged_first_fit_heap_allocator #(
    parameter int HEAP_UNITS = 4096,
    parameter int TAG_BITS   = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          op,
    input  wire logic [tffa_pkg::SIZE_W-1:0]   alloc_size,
    input  wire logic [tffa_pkg::ADDR_W-1:0]   free_addr,
    output logic                               done,
    output logic      [tffa_pkg::ADDR_W-1:0]   block_addr,
    output logic      [tffa_pkg::STAT_W-1:0]   status,
    input  wire logic                          cfg_we,
    input  wire logic [tffa_pkg::ADDR_W-1:0]   cfg_wdata
);

    localparam int OFF_W = $clog2(HEAP_UNITS);
    localparam int SUM_W = ((OFF_W > tffa_pkg::SIZE_W) ? OFF_W : tffa_pkg::SIZE_W) + 1;
    localparam logic [OFF_W-1:0] LAST_OFF = OFF_W'(HEAP_UNITS - 1);
    localparam logic [tffa_pkg::ADDR_W-1:0] HEAP_START_RST = 32'h1000_0000;

    tffa_pkg::state_t state_reg, state_next;

    logic [OFF_W-1:0]            idx_reg, idx_next;
    logic                        issue_done_reg, issue_done_next;
    logic                        chk_valid_reg, chk_valid_next;
    logic [OFF_W-1:0]            chk_idx_reg, chk_idx_next;
    logic [OFF_W-1:0]            limit_reg, limit_next;
    logic [OFF_W-1:0]            hw_reg, hw_next;
    logic [OFF_W-1:0]            start_reg, start_next;
    logic [OFF_W-1:0]            fill_end_reg, fill_end_next;
    logic [TAG_BITS-1:0]         tag_reg, tag_next;
    logic [TAG_BITS-1:0]         free_tag_reg, free_tag_next;
    logic [tffa_pkg::SIZE_W-1:0] size_reg, size_next;
    logic [tffa_pkg::ADDR_W-1:0] diff_reg, diff_next;
    logic [tffa_pkg::ADDR_W-1:0] heap_start_reg;
    logic                        done_reg, done_next;
    logic [tffa_pkg::ADDR_W-1:0] block_addr_reg, block_addr_next;
    logic [tffa_pkg::STAT_W-1:0] status_reg, status_next;

    logic                        ram_we;
    logic [OFF_W-1:0]            ram_waddr;
    logic [TAG_BITS-1:0]         ram_wdata;
    logic [OFF_W-1:0]            ram_raddr;
    logic [TAG_BITS-1:0]         ram_rdata;

    tffa_pkg::run_ctrl_t         run_ctrl;
    tffa_pkg::run_stat_t         run_stat;
    logic [OFF_W-1:0]            run_start;

    logic                        issue_en;
    logic [TAG_BITS-1:0]         tag_adv;
    logic [SUM_W-1:0]            last_sum;
    logic [OFF_W-1:0]            last_off;

    tffa_tag_ram #(
        .DEPTH  (HEAP_UNITS),
        .ADDR_W (OFF_W),
        .DATA_W (TAG_BITS)
    ) u_tag_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tffa_run_unit #(
        .OFF_W (OFF_W),
        .TAG_W (TAG_BITS)
    ) u_run_unit (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (run_ctrl),
        .rdata     (ram_rdata),
        .ref_tag   (free_tag_reg),
        .chk_idx   (chk_idx_reg),
        .size      (size_reg),
        .heap_lo   (heap_start_reg[tffa_pkg::ALIGN_BITS-1:0]),
        .stat      (run_stat),
        .start_off (run_start)
    );

    always_comb
    begin
        tag_adv  = tag_reg + TAG_BITS'(1);
        if (tag_adv == '0)
        begin
            tag_adv = TAG_BITS'(1);
        end
        last_sum = SUM_W'(hw_reg) + SUM_W'(size_reg);
        last_off = (last_sum > SUM_W'(HEAP_UNITS - 1)) ? LAST_OFF : last_sum[OFF_W-1:0];
        issue_en = !issue_done_reg && (idx_reg <= limit_reg);
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        issue_done_next = issue_done_reg;
        chk_valid_next  = 1'b0;
        chk_idx_next    = idx_reg;
        limit_next      = limit_reg;
        hw_next         = hw_reg;
        start_next      = start_reg;
        fill_end_next   = fill_end_reg;
        tag_next        = tag_reg;
        free_tag_next   = free_tag_reg;
        size_next       = size_reg;
        diff_next       = diff_reg;
        done_next       = 1'b0;
        block_addr_next = block_addr_reg;
        status_next     = status_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = '0;
        ram_raddr       = idx_reg;
        run_ctrl        = '{restart: 1'b0, step: 1'b0};

        unique case (state_reg)
            tffa_pkg::S_INIT:
            begin
                ram_we = 1'b1;
                if (idx_reg == LAST_OFF)
                begin
                    idx_next   = '0;
                    state_next = tffa_pkg::S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + OFF_W'(1);
                end
            end

            tffa_pkg::S_IDLE:
            begin
                if (start)
                begin
                    if (op == tffa_pkg::OP_ALLOC)
                    begin
                        if (alloc_size == '0)
                        begin
                            done_next       = 1'b1;
                            status_next     = tffa_pkg::ST_IGNORED;
                            block_addr_next = '0;
                        end
                        else
                        begin
                            tag_next   = tag_adv;
                            size_next  = alloc_size;
                            state_next = tffa_pkg::S_ALLOC;
                        end
                    end
                    else
                    begin
                        if (free_addr == '0)
                        begin
                            done_next       = 1'b1;
                            status_next     = tffa_pkg::ST_IGNORED;
                            block_addr_next = '0;
                        end
                        else
                        begin
                            diff_next  = free_addr - heap_start_reg;
                            state_next = tffa_pkg::S_FREE_CHK;
                        end
                    end
                end
            end

            tffa_pkg::S_ALLOC:
            begin
                limit_next      = last_off;
                idx_next        = '0;
                issue_done_next = 1'b0;
                run_ctrl.restart = 1'b1;
                state_next      = tffa_pkg::S_SCAN;
            end

            tffa_pkg::S_SCAN:
            begin
                // read unit idx while testing the unit read last cycle
                if (issue_en)
                begin
                    chk_valid_next = 1'b1;
                    idx_next       = idx_reg + OFF_W'(1);
                    if (idx_reg == limit_reg)
                    begin
                        issue_done_next = 1'b1;
                    end
                end
                run_ctrl.step = chk_valid_reg;
                if (chk_valid_reg && run_stat.fit)
                begin
                    start_next     = run_start;
                    idx_next       = run_start;
                    fill_end_next  = chk_idx_reg;
                    chk_valid_next = 1'b0;
                    state_next     = tffa_pkg::S_FILL;
                end
                else if (!chk_valid_reg && !issue_en)
                begin
                    done_next       = 1'b1;
                    status_next     = tffa_pkg::ST_NO_SPACE;
                    block_addr_next = '0;
                    state_next      = tffa_pkg::S_IDLE;
                end
            end

            tffa_pkg::S_FILL:
            begin
                ram_we    = 1'b1;
                ram_wdata = tag_reg;
                if (idx_reg == fill_end_reg)
                begin
                    if (fill_end_reg > hw_reg)
                    begin
                        hw_next = fill_end_reg;
                    end
                    done_next       = 1'b1;
                    status_next     = tffa_pkg::ST_DONE;
                    block_addr_next = heap_start_reg + tffa_pkg::ADDR_W'(start_reg);
                    state_next      = tffa_pkg::S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + OFF_W'(1);
                end
            end

            tffa_pkg::S_FREE_CHK:
            begin
                ram_raddr       = diff_reg[OFF_W-1:0];
                idx_next        = diff_reg[OFF_W-1:0];
                limit_next      = hw_reg;
                issue_done_next = 1'b0;
                if (diff_reg >= tffa_pkg::ADDR_W'(HEAP_UNITS))
                begin
                    done_next       = 1'b1;
                    status_next     = tffa_pkg::ST_BAD_FREE;
                    block_addr_next = '0;
                    state_next      = tffa_pkg::S_IDLE;
                end
                else
                begin
                    state_next = tffa_pkg::S_FREE_TAG;
                end
            end

            tffa_pkg::S_FREE_TAG:
            begin
                if (run_stat.unit_free)
                begin
                    done_next       = 1'b1;
                    status_next     = tffa_pkg::ST_BAD_FREE;
                    block_addr_next = '0;
                    state_next      = tffa_pkg::S_IDLE;
                end
                else
                begin
                    free_tag_next = ram_rdata;
                    state_next    = tffa_pkg::S_CLR;
                end
            end

            tffa_pkg::S_CLR:
            begin
                if (issue_en)
                begin
                    chk_valid_next = 1'b1;
                    idx_next       = idx_reg + OFF_W'(1);
                    if (idx_reg == limit_reg)
                    begin
                        issue_done_next = 1'b1;
                    end
                end
                if (chk_valid_reg)
                begin
                    if (run_stat.tag_match)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = chk_idx_reg;
                    end
                    else
                    begin
                        done_next       = 1'b1;
                        status_next     = tffa_pkg::ST_DONE;
                        block_addr_next = '0;
                        state_next      = tffa_pkg::S_IDLE;
                    end
                end
                else if (!issue_en)
                begin
                    done_next       = 1'b1;
                    status_next     = tffa_pkg::ST_DONE;
                    block_addr_next = '0;
                    state_next      = tffa_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = tffa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tffa_pkg::S_INIT;
            idx_reg        <= '0;
            issue_done_reg <= 1'b0;
            chk_valid_reg  <= 1'b0;
            limit_reg      <= '0;
            hw_reg         <= '0;
            tag_reg        <= TAG_BITS'(1);
            heap_start_reg <= HEAP_START_RST;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            issue_done_reg <= issue_done_next;
            chk_valid_reg  <= chk_valid_next;
            limit_reg      <= limit_next;
            hw_reg         <= hw_next;
            tag_reg        <= tag_next;
            done_reg       <= done_next;
            if (cfg_we)
            begin
                heap_start_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg    <= chk_idx_next;
        start_reg      <= start_next;
        fill_end_reg   <= fill_end_next;
        free_tag_reg   <= free_tag_next;
        size_reg       <= size_next;
        diff_reg       <= diff_next;
        block_addr_reg <= block_addr_next;
        status_reg     <= status_next;
    end

    assign busy       = (state_reg != tffa_pkg::S_IDLE);
    assign done       = done_reg;
    assign block_addr = block_addr_reg;
    assign status     = status_reg;

`ifndef NO_ASSERTIONS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted request neither started nor answered");

    a_alloc_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == tffa_pkg::ST_DONE && block_addr != '0)
            |-> (block_addr[tffa_pkg::ALIGN_BITS-1:0] == '0))
        else $error("allocated block not aligned");

    a_hw_range: assert property (@(posedge clk) disable iff (!rst_n)
        hw_reg <= LAST_OFF)
        else $error("high-water mark beyond store");

    a_tag_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        tag_reg != '0)
        else $error("block tag is zero");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/tffa_heap_checker.sv -----
// ----------------------------------------------------------------------------
// tffa_heap_checker
// Watches the request, result and heap-base ports of the allocator. It keeps
// its own copy of the tag store, high-water mark, block tag and heap base,
// predicts the reply to every accepted request and compares each result beat,
// field by field, against the oldest reply still owed.
// ----------------------------------------------------------------------------
module tffa_heap_checker #(
    parameter int HEAP_UNITS = 4096,
    parameter int TAG_BITS   = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          op,
    input  logic [tffa_pkg::SIZE_W-1:0]   alloc_size,
    input  logic [tffa_pkg::ADDR_W-1:0]   free_addr,
    input  logic                          done,
    input  logic [tffa_pkg::ADDR_W-1:0]   block_addr,
    input  logic [tffa_pkg::STAT_W-1:0]   status,
    input  logic                          cfg_we,
    input  logic [tffa_pkg::ADDR_W-1:0]   cfg_wdata,
    output int                            err_count,
    output int                            replies_owed,
    output int                            n_placed,
    output int                            n_freed,
    output int                            n_no_space,
    output int                            n_bad_free,
    output int                            n_ignored
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SIZE_W     = tffa_pkg::SIZE_W;
    localparam int ADDR_W     = tffa_pkg::ADDR_W;
    localparam int STAT_W     = tffa_pkg::STAT_W;
    localparam int ALIGN_BITS = tffa_pkg::ALIGN_BITS;

    localparam logic [ADDR_W-1:0] HEAP_BASE_RST = 32'h1000_0000;

    typedef struct packed {
        logic              is_free;
        logic [ADDR_W-1:0] addr;
        logic [STAT_W-1:0] stat;
    } heap_reply_t;

    heap_reply_t         replies_due[$];
    logic [TAG_BITS-1:0] unit_tag_m [HEAP_UNITS];
    int unsigned         high_water_m;
    logic [TAG_BITS-1:0] block_tag_m;
    logic [ADDR_W-1:0]   heap_base_m;

    int errs     = 0;
    int owed     = 0;
    int placed   = 0;
    int freed    = 0;
    int no_space = 0;
    int bad_free = 0;
    int ignored  = 0;

    assign err_count    = errs;
    assign replies_owed = owed;
    assign n_placed     = placed;
    assign n_freed      = freed;
    assign n_no_space   = no_space;
    assign n_bad_free   = bad_free;
    assign n_ignored    = ignored;

    task automatic flag_mismatch(input string what);
        errs++;
        $display("MISMATCH @%0t: %s", $time, what);
    endtask

    // first fit: lowest run of free units whose absolute start is aligned
    task automatic place_block(input logic [SIZE_W-1:0] size, output heap_reply_t r);
        int unsigned       last_u;
        int unsigned       run_len;
        int unsigned       first_u;
        logic [ADDR_W-1:0] abs_a;
        bit                found;
        r.is_free = 1'b0;
        r.addr    = '0;
        r.stat    = tffa_pkg::ST_NO_SPACE;
        found     = 1'b0;
        if (size == '0)
        begin
            r.stat = tffa_pkg::ST_IGNORED;
        end
        else
        begin
            // tag moves on even when nothing fits; 0 is reserved for free
            block_tag_m = block_tag_m + TAG_BITS'(1);
            if (block_tag_m == '0)
                block_tag_m = TAG_BITS'(1);
            last_u = high_water_m + size;
            if (last_u > HEAP_UNITS - 1)
                last_u = HEAP_UNITS - 1;
            run_len = 0;
            for (int unsigned i = 0; i <= last_u && !found; i++)
            begin
                if (unit_tag_m[i] == '0)
                    run_len++;
                else
                    run_len = 0;
                if (run_len >= size)
                begin
                    first_u = i + 1 - size;
                    abs_a   = heap_base_m + first_u;
                    if (abs_a[ALIGN_BITS-1:0] == '0)
                    begin
                        for (int unsigned j = first_u; j <= i; j++)
                            unit_tag_m[j] = block_tag_m;
                        if (i > high_water_m)
                            high_water_m = i;
                        r.addr = abs_a;
                        r.stat = tffa_pkg::ST_DONE;
                        found  = 1'b1;
                    end
                end
            end
        end
    endtask

    task automatic release_block(input logic [ADDR_W-1:0] addr, output heap_reply_t r);
        logic [ADDR_W-1:0]   off;
        logic [TAG_BITS-1:0] victim;
        int unsigned         k;
        r.is_free = 1'b1;
        r.addr    = '0;
        if (addr == '0)
        begin
            r.stat = tffa_pkg::ST_IGNORED;
        end
        else
        begin
            off = addr - heap_base_m;
            if (off >= HEAP_UNITS || unit_tag_m[off] == '0)
            begin
                r.stat = tffa_pkg::ST_BAD_FREE;
            end
            else
            begin
                // clear onward while the tag holds, bounded by high water and store end
                victim = unit_tag_m[off];
                k      = off;
                while (k <= high_water_m && k < HEAP_UNITS && unit_tag_m[k] == victim)
                begin
                    unit_tag_m[k] = '0;
                    k++;
                end
                r.stat = tffa_pkg::ST_DONE;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        heap_reply_t want;
        if (!rst_n)
        begin
            for (int u = 0; u < HEAP_UNITS; u++)
                unit_tag_m[u] = '0;
            high_water_m = 0;
            block_tag_m  = TAG_BITS'(1);
            heap_base_m  = HEAP_BASE_RST;
            replies_due.delete();
            owed = 0;
        end
        else
        begin
            if (cfg_we)
                heap_base_m = cfg_wdata;
            if (start && !busy)
            begin
                if (op == tffa_pkg::OP_ALLOC)
                    place_block(alloc_size, want);
                else
                    release_block(free_addr, want);
                replies_due.push_back(want);
            end
            if (done)
            begin
                if (replies_due.size() == 0)
                begin
                    flag_mismatch($sformatf("result beat with nothing owed (addr %h status %0d)",
                                            block_addr, status));
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (block_addr !== want.addr)
                        flag_mismatch($sformatf("%s block_addr %h, predicted %h",
                                                want.is_free ? "free" : "alloc",
                                                block_addr, want.addr));
                    if (status !== want.stat)
                        flag_mismatch($sformatf("%s status %0d, predicted %0d",
                                                want.is_free ? "free" : "alloc",
                                                status, want.stat));
                    case (want.stat)
                        tffa_pkg::ST_DONE:     if (want.is_free) freed++; else placed++;
                        tffa_pkg::ST_IGNORED:  ignored++;
                        tffa_pkg::ST_NO_SPACE: no_space++;
                        default:               bad_free++;
                    endcase
                end
            end
            owed = replies_due.size();
        end
    end

endmodule

// ----- tb/sv/tb_tagged_first_fit_heap_allocator.sv -----
// ----------------------------------------------------------------------------
// tb_tagged_first_fit_heap_allocator
// Drives allocate and free requests into the heap allocator in bursts with
// random gaps, moves the heap base between phases (aligned, unaligned and
// wrapping around zero) and leaves prediction and comparison to the checker.
// ----------------------------------------------------------------------------
module tb_tagged_first_fit_heap_allocator;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int                SIZE_W        = tffa_pkg::SIZE_W;
    localparam int                ADDR_W        = tffa_pkg::ADDR_W;
    localparam int                STAT_W        = tffa_pkg::STAT_W;
    localparam int                HEAP_UNITS    = 4096;
    localparam int                TAG_BITS      = 16;
    localparam logic [ADDR_W-1:0] HEAP_BASE_RST = 32'h1000_0000;
    localparam int                N_PHASES      = 5;
    localparam int                RANDOM_ITEMS  = 115;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              start      = 1'b0;
    logic              op         = tffa_pkg::OP_ALLOC;
    logic [SIZE_W-1:0] alloc_size = '0;
    logic [ADDR_W-1:0] free_addr  = '0;
    logic              cfg_we     = 1'b0;
    logic [ADDR_W-1:0] cfg_wdata  = '0;
    logic              busy;
    logic              done;
    logic [ADDR_W-1:0] block_addr;
    logic [STAT_W-1:0] status;

    int err_count, replies_owed;
    int n_placed, n_freed, n_no_space, n_bad_free, n_ignored;

    logic [ADDR_W-1:0] heap_now   = HEAP_BASE_RST;
    int unsigned       live_offs[$];
    int                burst_left = 0;
    int                n_sent     = 0;
    int                n_bases    = 0;

    tagged_first_fit_heap_allocator #(
        .HEAP_UNITS (HEAP_UNITS),
        .TAG_BITS   (TAG_BITS)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .op         (op),
        .alloc_size (alloc_size),
        .free_addr  (free_addr),
        .done       (done),
        .block_addr (block_addr),
        .status     (status),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata)
    );

    tffa_heap_checker #(
        .HEAP_UNITS (HEAP_UNITS),
        .TAG_BITS   (TAG_BITS)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .alloc_size   (alloc_size),
        .free_addr    (free_addr),
        .done         (done),
        .block_addr   (block_addr),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .err_count    (err_count),
        .replies_owed (replies_owed),
        .n_placed     (n_placed),
        .n_freed      (n_freed),
        .n_no_space   (n_no_space),
        .n_bad_free   (n_bad_free),
        .n_ignored    (n_ignored)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // run limit, well above the slowest legal run
    initial
    begin
        #200_000_000;
        $display("Timeout with %0d replies still owed", replies_owed);
        $display("DONE: errors detected");
        $finish;
    end

    // collect placed blocks as offsets so frees stay valid across base moves
    always @(negedge clk)
    begin
        if (rst_n && done && status == tffa_pkg::ST_DONE && block_addr != '0)
            live_offs.push_back(block_addr - heap_now);
    end

    // all tasks are entered and left on a rising-edge time step
    task automatic issue(input logic o, input logic [SIZE_W-1:0] sz,
                         input logic [ADDR_W-1:0] fa);
        start      <= 1'b1;
        op         <= o;
        alloc_size <= sz;
        free_addr  <= fa;
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
        n_sent++;
    endtask

    task automatic alloc_req(input logic [SIZE_W-1:0] sz);
        issue(tffa_pkg::OP_ALLOC, sz, $urandom);
    endtask

    task automatic free_req(input logic [ADDR_W-1:0] fa);
        issue(tffa_pkg::OP_FREE, SIZE_W'($urandom), fa);
    endtask

    task automatic pace();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            start <= 1'b0;
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 30)
                                                      : $urandom_range(0, 6);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        while (replies_owed != 0 || busy)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic set_base(input logic [ADDR_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        heap_now  = v;
        n_bases++;
    endtask

    // mostly small blocks, a few large ones, the odd zero or oversize
    function automatic logic [SIZE_W-1:0] pick_size();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 70)
            return SIZE_W'($urandom_range(1, 16));
        else if (p < 90)
            return SIZE_W'($urandom_range(17, 128));
        else if (p < 96)
            return SIZE_W'($urandom_range(129, 1024));
        else if (p < 97)
            return '0;
        else if (p < 98)
            return SIZE_W'(HEAP_UNITS);
        else
            return SIZE_W'($urandom_range(HEAP_UNITS + 1, 8191));
    endfunction

    task automatic random_req(output bit counted);
        int unsigned       p;
        int unsigned       idx;
        int unsigned       off;
        logic [SIZE_W-1:0] sz;
        p = $urandom_range(0, 99);
        counted = 1'b1;
        if (p < 50 || (p < 80 && live_offs.size() == 0))
        begin
            sz = pick_size();
            counted = (sz != '0);
            alloc_req(sz);
        end
        else if (p < 80)
        begin
            idx = $urandom_range(0, live_offs.size() - 1);
            off = live_offs[idx];
            live_offs.delete(idx);
            // now and then free from inside the block
            if ($urandom_range(0, 4) == 0)
                off += $urandom_range(1, 3);
            free_req(heap_now + off);
        end
        else if (p < 88)
        begin
            free_req(heap_now + $urandom_range(0, HEAP_UNITS - 1));
        end
        else if (p < 95)
        begin
            free_req($urandom);
        end
        else
        begin
            counted = 1'b0;
            free_req('0);
        end
    endtask

    initial
    begin : stimulus
        logic [ADDR_W-1:0] bases[N_PHASES];
        logic [ADDR_W-1:0] b;
        bit                counted;
        int                n_real;
        bases = '{32'h0000_0000, 32'h8000_0002, 32'hFFFF_FFFC, HEAP_BASE_RST, 32'h0};
        bases[N_PHASES-1] = $urandom;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        // tag store clearing pass
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);

        set_base(HEAP_BASE_RST);
        b = HEAP_BASE_RST;
        alloc_req(SIZE_W'(0));     pace();
        alloc_req(SIZE_W'(1));     pace();
        alloc_req(SIZE_W'(3));     pace();
        alloc_req(SIZE_W'(8));     pace();
        free_req('0);              pace();
        free_req(b + 5);           pace();   // inside a block
        free_req(b + 5);           pace();   // already free
        free_req(b + 4);           pace();
        free_req(b + HEAP_UNITS);  pace();   // just past the store
        free_req(b - 1);           pace();
        free_req(b + HEAP_UNITS - 1); pace();
        alloc_req(SIZE_W'(8191));  pace();
        alloc_req(SIZE_W'(HEAP_UNITS)); pace();
        free_req(b);               pace();
        free_req(b + 8);           pace();
        alloc_req(SIZE_W'(HEAP_UNITS)); pace();   // whole store
        alloc_req(SIZE_W'(1));     pace();   // full
        free_req(b + HEAP_UNITS - 1); pace(); // last unit only
        free_req(b);               pace();
        free_req(32'hFFFF_FFFF);   pace();

        // base just below zero: first aligned block lands at address 0
        drain();
        set_base(32'hFFFF_FFFE);
        alloc_req(SIZE_W'(1));     pace();
        free_req('0);              pace();
        drain();
        set_base(32'hFFFF_FFFF);
        alloc_req(SIZE_W'(2));     pace();
        free_req(32'h0000_0004);   pace();

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            drain();
            set_base(bases[ph]);
            n_real = 0;
            while (n_real < RANDOM_ITEMS / N_PHASES)
            begin
                random_req(counted);
                if (counted)
                    n_real++;
                if ($urandom_range(0, 19) == 0)
                    drain();
                else
                    pace();
            end
        end

        drain();
        repeat (16) @(posedge clk);
        $display("Summary: %0d requests over %0d heap bases; %0d blocks placed, %0d freed",
                 n_sent, n_bases, n_placed, n_freed);
        $display("Summary: %0d out of space, %0d rejected frees, %0d ignored",
                 n_no_space, n_bad_free, n_ignored);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
